### hdl/pop3_response_framer_macros.svh
// ---------------------------------------------------------------------------
// pop3 response framer assertion macros
// shared property wrappers clocked on clock and disabled in reset
// ---------------------------------------------------------------------------
`ifndef POP3_RESPONSE_FRAMER_MACROS_SVH
`define POP3_RESPONSE_FRAMER_MACROS_SVH

// same-cycle implication
`define P3RF_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("p3rf assertion failed");

// next-cycle implication
`define P3RF_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("p3rf assertion failed");

`endif

### hdl/p3rf_pkg.sv
// ---------------------------------------------------------------------------
// p3rf_pkg
// types and constants shared by the pop3 response framer
// ---------------------------------------------------------------------------
package p3rf_pkg;

   localparam int unsigned CountWidth = 10;
   localparam int unsigned TermWidth  = 3;

   localparam logic [CountWidth-1:0] CountMax        = 10'd1023;
   localparam logic [CountWidth-1:0] MaxBytesDefault = 10'd512;

   // characters of the framing
   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChLf    = 8'h0A;
   localparam logic [7:0] ChDot   = 8'h2E;
   localparam logic [7:0] ChPlus  = 8'h2B;
   localparam logic [7:0] ChO     = 8'h4F;
   localparam logic [7:0] ChK     = 8'h4B;
   localparam logic [7:0] ChMinus = 8'h2D;
   localparam logic [7:0] ChE     = 8'h45;
   localparam logic [7:0] ChR     = 8'h52;

   // terminator position codes
   localparam logic [TermWidth-1:0] TpNone   = 3'd0;
   localparam logic [TermWidth-1:0] TpCr     = 3'd1;
   localparam logic [TermWidth-1:0] TpLineLf = 3'd2;
   localparam logic [TermWidth-1:0] TpDot    = 3'd3;
   localparam logic [TermWidth-1:0] TpDotCr  = 3'd4;
   localparam logic [TermWidth-1:0] TpFinal  = 3'd5;

   typedef enum logic [3:0] {
      PH_INIT     = 4'd0,
      PH_OK       = 4'd1,
      PH_ERR      = 4'd2,
      PH_TEXT     = 4'd3,
      PH_LINE_END = 4'd4,
      PH_BODY     = 4'd5,
      PH_TERM     = 4'd6,
      PH_DONE     = 4'd7,
      PH_ERROR    = 4'd8
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       expect_multiline;
      logic       start_new;
   } req_type;

   typedef struct packed {
      logic [3:0] parse_state;
      logic       status_positive;
      logic       error_flag;
      logic       done_flag;
   } rsp_type;

   typedef struct packed {
      phase_type              phase;
      logic [CountWidth-1:0]  line_position;
      logic [TermWidth-1:0]   terminator_position;
      logic [CountWidth-1:0]  bytes_seen;
      logic                   positive_status;
   } parser_state_type;

   localparam parser_state_type ParserClear = '{
      phase:               PH_INIT,
      line_position:       '0,
      terminator_position: TpNone,
      bytes_seen:          '0,
      positive_status:     1'b0
   };

endpackage

### hdl/pop3_response_framer.sv
// ---------------------------------------------------------------------------
// pop3_response_framer
// follows the framing of a pop3 server reply one byte per request
// ---------------------------------------------------------------------------
//  channel  direction  payload                       handshake
//  req      in         data byte, multiline, start   req_valid / req_ready
//  rsp      out        state, status, error, done    rsp_valid / rsp_ready
//  csr      in         max_response_bytes (10 bit)   csr_valid / csr_ready
//
//  one request per cycle sustained while rsp_ready is high; a request reaches rsp
//  through the input register, then the result register
//  the framing state updates once per step, which sets that rate
//  reset clears the parser, both stage valids and restores the limit to 512
//  a stalled rsp holds its result while the input register still takes one
// ---------------------------------------------------------------------------
`include "pop3_response_framer_macros.svh"

module pop3_response_framer
   import p3rf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CountWidth-1:0] csr_data
);

   logic                  s1_valid;
   req_type               s1_data;
   logic                  step;
   rsp_type               step_rsp;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic [CountWidth-1:0] max_bytes_ff, max_bytes_in;

   // held request present and result register free or draining this cycle
   assign step = s1_valid && (!rsp_valid_ff || rsp_ready);

   p3rf_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .drain      (step),
      .hold_valid (s1_valid),
      .hold_data  (s1_data)
   );

   p3rf_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step),
      .step_req  (s1_data),
      .max_bytes (max_bytes_ff),
      .step_rsp  (step_rsp)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // length limit register
   assign csr_ready    = 1'b1;
   assign max_bytes_in = csr_valid ? csr_data : max_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         max_bytes_ff <= MaxBytesDefault;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         max_bytes_ff <= max_bytes_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `P3RF_ASSERT_IMP(a_flags_exclusive, rsp_valid, !(rsp_data.error_flag && rsp_data.done_flag))
   `P3RF_ASSERT_IMP(a_stall_means_held, !req_ready, s1_valid && rsp_valid_ff && !rsp_ready)
   `P3RF_ASSERT_NXT(a_step_loads_result, step, rsp_valid_ff)

endmodule

### hdl/p3rf_in_stage.sv
// ---------------------------------------------------------------------------
// p3rf_in_stage
// input register for requests, refilled in the cycle it is drained
// ---------------------------------------------------------------------------
module p3rf_in_stage
   import p3rf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    drain,
   output logic    hold_valid,
   output req_type hold_data
);

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;
   logic    take;

   // accept when empty or when the held request leaves this cycle
   assign req_ready = !valid_ff || drain;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (take) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (drain) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign hold_valid = valid_ff;
   assign hold_data  = data_ff;

endmodule

### hdl/p3rf_parser.sv
// ---------------------------------------------------------------------------
// p3rf_parser
// framing state and one-byte step logic of the pop3 reply parser
// ---------------------------------------------------------------------------
module p3rf_parser
   import p3rf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  req_type               step_req,
   input  logic [CountWidth-1:0] max_bytes,
   output rsp_type               step_rsp
);

   parser_state_type state_ff, state_in;
   parser_state_type cur;
   parser_state_type nxt;
   logic [7:0]       b;
   logic             ok_match;
   logic             err_match;

   assign b = step_req.data_byte;

   // start from a cleared parser when a new response begins
   assign cur = step_req.start_new ? ParserClear : state_ff;

   // expected indicator characters at the current line position
   always_comb begin
      case (cur.line_position)
         10'd0:   ok_match = (b == ChPlus);
         10'd1:   ok_match = (b == ChO);
         10'd2:   ok_match = (b == ChK);
         default: ok_match = 1'b0;
      endcase
      case (cur.line_position)
         10'd0:   err_match = (b == ChMinus);
         10'd1:   err_match = (b == ChE);
         10'd2:   err_match = (b == ChR);
         10'd3:   err_match = (b == ChR);
         default: err_match = 1'b0;
      endcase
   end

   // one framing step
   always_comb begin
      nxt = cur;
      case (cur.phase)
         PH_INIT: begin
            if (b == ChPlus) begin
               nxt.phase           = PH_OK;
               nxt.positive_status = 1'b1;
               nxt.line_position   = 10'd1;
            end else if (b == ChMinus) begin
               nxt.phase           = PH_ERR;
               nxt.positive_status = 1'b0;
               nxt.line_position   = 10'd1;
            end else begin
               nxt.phase = PH_ERROR;
            end
         end
         PH_OK: begin
            if (!ok_match) begin
               nxt.phase = PH_ERROR;
            end else begin
               if (cur.line_position == 10'd2) nxt.phase = PH_TEXT;
               nxt.line_position = cur.line_position + 10'd1;
            end
         end
         PH_ERR: begin
            if (!err_match) begin
               nxt.phase = PH_ERROR;
            end else begin
               if (cur.line_position == 10'd3) nxt.phase = PH_TEXT;
               nxt.line_position = cur.line_position + 10'd1;
            end
         end
         PH_TEXT: begin
            if (b == ChCr) begin
               nxt.phase               = PH_LINE_END;
               nxt.terminator_position = TpCr;
            end
         end
         PH_LINE_END: begin
            if (b != ChLf) begin
               nxt.phase = PH_ERROR;
            end else if (step_req.expect_multiline && cur.positive_status) begin
               nxt.phase               = PH_BODY;
               nxt.line_position       = '0;
               nxt.terminator_position = TpLineLf;
            end else begin
               nxt.phase = PH_DONE;
            end
         end
         PH_BODY: begin
            if (b == ChCr) begin
               nxt.terminator_position = TpCr;
            end else if (b == ChLf) begin
               if (cur.terminator_position != TpCr) begin
                  nxt.phase = PH_ERROR;
               end else begin
                  nxt.line_position       = '0;
                  nxt.terminator_position = TpLineLf;
               end
            end else if (b == ChDot && cur.line_position == '0) begin
               nxt.phase               = PH_TERM;
               nxt.terminator_position = TpDot;
            end else if (cur.line_position != CountMax) begin
               nxt.line_position = cur.line_position + 10'd1;
            end
         end
         PH_TERM: begin
            if (cur.terminator_position == TpDot) begin
               if (b == ChCr) begin
                  nxt.terminator_position = TpDotCr;
               end else begin
                  // dot-stuffed line, byte counts as content
                  nxt.phase               = PH_BODY;
                  nxt.terminator_position = TpNone;
                  nxt.line_position       = 10'd1;
               end
            end else if (cur.terminator_position == TpDotCr && b == ChLf) begin
               nxt.phase               = PH_DONE;
               nxt.terminator_position = TpFinal;
            end else begin
               nxt.phase = PH_ERROR;
            end
         end
         default: begin
            nxt.phase = PH_ERROR;
         end
      endcase

      // length limit and saturating byte count
      if (cur.bytes_seen >= max_bytes) nxt.phase = PH_ERROR;
      if (cur.bytes_seen != CountMax) nxt.bytes_seen = cur.bytes_seen + 10'd1;
   end

   assign state_in = step_en ? nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ParserClear;
      end else begin
         state_ff <= state_in;
      end
   end

   // result of this step
   always_comb begin
      step_rsp.parse_state     = nxt.phase;
      step_rsp.status_positive = nxt.positive_status;
      step_rsp.error_flag      = (nxt.phase == PH_ERROR);
      step_rsp.done_flag       = (nxt.phase == PH_DONE);
   end

endmodule
